FILE: src/blt_pkg.sv
// ----------------------------------------------------------------------------
// Blitter package
// Shared constants, codes and types of the clipped block blitter.
// ----------------------------------------------------------------------------
package blt_pkg;

   localparam int FRAME_BYTES_DEF = 65536;
   localparam int MAX_SIDE_DEF    = 1024;
   localparam int ADDR_MAX_W      = 20;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = 2;
   localparam int CSR_ADDR_W      = 5;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_PIXEL = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_TABLE = 2'd3;

   localparam logic [2:0] MODE_GET      = 3'd0;
   localparam logic [2:0] MODE_PUT      = 3'd1;
   localparam logic [2:0] MODE_MASKED   = 3'd2;
   localparam logic [2:0] MODE_SHADOW   = 3'd3;
   localparam logic [2:0] MODE_RECOLOUR = 3'd4;
   localparam logic [2:0] MODE_BOX      = 3'd5;

   localparam logic [2:0] REG_CLIP_LEFT = 3'd0;
   localparam logic [2:0] REG_CLIP_TOP  = 3'd1;
   localparam logic [2:0] REG_CLIP_COLS = 3'd2;
   localparam logic [2:0] REG_CLIP_ROWS = 3'd3;
   localparam logic [2:0] REG_ORIGIN_X  = 3'd4;
   localparam logic [2:0] REG_ORIGIN_Y  = 3'd5;
   localparam logic [2:0] REG_PITCH     = 3'd6;
   localparam logic [2:0] REG_SHADOW    = 3'd7;

   typedef enum logic [2:0] {
      CMD_REPORT,
      CMD_WRITE,
      CMD_TLOAD,
      CMD_RECOLOUR,
      CMD_GET
   } blt_cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RC_TBL,
      BK_RC_WR,
      BK_GET_OUT
   } blt_back_state_type;

   typedef struct packed {
      logic [9:0]  clip_left;
      logic [9:0]  clip_top;
      logic [10:0] clip_cols;
      logic [10:0] clip_rows;
      logic [10:0] origin_x;
      logic [10:0] origin_y;
      logic [10:0] row_pitch;
      logic [7:0]  shadow_colour;
   } blt_cfg_type;

   typedef struct packed {
      blt_cmd_type            kind;
      logic [ADDR_MAX_W-1:0]  addr;
      logic [7:0]             data;
      logic [19:0]            idx;
      logic                   last;
      logic [15:0]            rect_x;
      logic [15:0]            rect_y;
      logic [10:0]            rect_cols;
      logic [10:0]            rect_rows;
      logic                   rect_empty;
   } blt_entry_type;

endpackage

FILE: src/clipped_block_blitter.sv
// ----------------------------------------------------------------------------
// Clipped block blitter
// Byte-per-pixel blitter with clip rectangle, offsets and recolour table.
// ----------------------------------------------------------------------------
// The front end takes one request per cycle while the four-entry command
// queue has room; it clips start commands and walks pixel positions itself.
// The back end owns the single-port frame store. From idle it carries out a
// report, a plain write or a table load directly, a get pixel as a frame read
// and then its response, and a recolour pixel as a frame read, a table read
// and a frame write in turn, so that frame store sequence sets the command rate.
// FRAME_BYTES must be a power of two; frame addresses wrap at that size.
module clipped_block_blitter #(
   parameter int FRAME_BYTES = blt_pkg::FRAME_BYTES_DEF,
   parameter int MAX_SIDE    = blt_pkg::MAX_SIDE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // mode, pos_x, pos_y, block_cols, block_rows, src_pixel, table_index, table_value
   input  logic [87:0]                    req_tdata,
   // op
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // rect_x, rect_y, rect_cols, rect_rows, rect_empty, read_pixel, buffer_index
   output logic [87:0]                    rsp_tdata,
   // kind
   output logic                           rsp_tuser,
   output logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [blt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   blt_pkg::blt_cfg_type   cfg;
   blt_pkg::blt_entry_type push_entry, head;
   logic push, full, pop, head_valid;
   logic [82:0] rsp_data;

   assign rsp_tdata = {5'd0, rsp_data};

   blt_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   blt_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser),
      .req_data   (req_tdata[80:0]),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   blt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   blt_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_tlast)
   );

endmodule

FILE: src/blt_regs.sv
// ----------------------------------------------------------------------------
// Blitter registers
// Configuration registers behind a write-and-read register port.
// ----------------------------------------------------------------------------
module blt_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [blt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output blt_pkg::blt_cfg_type            cfg
);

   blt_pkg::blt_cfg_type cfg_ff, cfg_in;
   logic [2:0] index;

   assign index      = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (index)
            blt_pkg::REG_CLIP_LEFT: cfg_in.clip_left     = csr_pwdata[9:0];
            blt_pkg::REG_CLIP_TOP:  cfg_in.clip_top      = csr_pwdata[9:0];
            blt_pkg::REG_CLIP_COLS: cfg_in.clip_cols     = csr_pwdata[10:0];
            blt_pkg::REG_CLIP_ROWS: cfg_in.clip_rows     = csr_pwdata[10:0];
            blt_pkg::REG_ORIGIN_X:  cfg_in.origin_x      = csr_pwdata[10:0];
            blt_pkg::REG_ORIGIN_Y:  cfg_in.origin_y      = csr_pwdata[10:0];
            blt_pkg::REG_PITCH:     cfg_in.row_pitch     = csr_pwdata[10:0];
            blt_pkg::REG_SHADOW:    cfg_in.shadow_colour = csr_pwdata[7:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         blt_pkg::REG_CLIP_LEFT: csr_prdata = {22'd0, cfg_ff.clip_left};
         blt_pkg::REG_CLIP_TOP:  csr_prdata = {22'd0, cfg_ff.clip_top};
         blt_pkg::REG_CLIP_COLS: csr_prdata = {21'd0, cfg_ff.clip_cols};
         blt_pkg::REG_CLIP_ROWS: csr_prdata = {21'd0, cfg_ff.clip_rows};
         blt_pkg::REG_ORIGIN_X:  csr_prdata = {21'd0, cfg_ff.origin_x};
         blt_pkg::REG_ORIGIN_Y:  csr_prdata = {21'd0, cfg_ff.origin_y};
         blt_pkg::REG_PITCH:     csr_prdata = {21'd0, cfg_ff.row_pitch};
         blt_pkg::REG_SHADOW:    csr_prdata = {24'd0, cfg_ff.shadow_colour};
         default:                csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_left     <= 10'd0;
         cfg_ff.clip_top      <= 10'd0;
         cfg_ff.clip_cols     <= 11'd320;
         cfg_ff.clip_rows     <= 11'd200;
         cfg_ff.origin_x      <= 11'd0;
         cfg_ff.origin_y      <= 11'd0;
         cfg_ff.row_pitch     <= 11'd320;
         cfg_ff.shadow_colour <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: src/blt_front.sv
// ----------------------------------------------------------------------------
// Blitter front end
// Accepts requests, clips blocks, walks pixel positions and issues commands.
// ----------------------------------------------------------------------------
module blt_front #(
   parameter int MAX_SIDE = blt_pkg::MAX_SIDE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  blt_pkg::blt_cfg_type   cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_op,
   input  logic [80:0]            req_data,
   input  logic                   queue_full,
   output logic                   push,
   output blt_pkg::blt_entry_type push_entry
);

   logic        busy_ff, busy_in;
   logic [2:0]  mode_ff, mode_in;
   logic [10:0] bx_ff, bx_in, by_ff, by_in;
   logic [10:0] bcols_ff, bcols_in, brows_ff, brows_in;
   logic [10:0] skc_ff, skc_in, skr_ff, skr_in;
   logic [10:0] svc_ff, svc_in, svr_ff, svr_in;
   logic [10:0] col_ff, col_in, row_ff, row_in;

   logic [2:0]  mode;
   logic [15:0] pos_x, pos_y;
   logic [10:0] bc_raw, br_raw, bc, br;
   logic [7:0]  src, tidx, tval;
   logic signed [17:0] x, y, x2, y2, cx1, cy1, cx2, cy2, lx, ty, rx, rb;
   logic        empty, in_clip;
   logic [11:0] ax, ay, cnext, rnext, skr_row;
   logic [22:0] prod, iprod;
   logic [23:0] asum, isum;

   assign mode   = req_data[2:0];
   assign pos_x  = req_data[18:3];
   assign pos_y  = req_data[34:19];
   assign bc_raw = req_data[45:35];
   assign br_raw = req_data[56:46];
   assign src    = req_data[64:57];
   assign tidx   = req_data[72:65];
   assign tval   = req_data[80:73];

   assign req_ready = !queue_full;

   always_comb begin
      bc = ({21'd0, bc_raw} > 32'(MAX_SIDE)) ? 11'(MAX_SIDE) : bc_raw;
      br = ({21'd0, br_raw} > 32'(MAX_SIDE)) ? 11'(MAX_SIDE) : br_raw;
      x   = $signed({{2{pos_x[15]}}, pos_x}) + $signed({{7{cfg.origin_x[10]}}, cfg.origin_x});
      y   = $signed({{2{pos_y[15]}}, pos_y}) + $signed({{7{cfg.origin_y[10]}}, cfg.origin_y});
      x2  = x + $signed({7'd0, bc}) - 18'sd1;
      y2  = y + $signed({7'd0, br}) - 18'sd1;
      cx1 = $signed({8'd0, cfg.clip_left});
      cy1 = $signed({8'd0, cfg.clip_top});
      cx2 = cx1 + $signed({7'd0, cfg.clip_cols}) - 18'sd1;
      cy2 = cy1 + $signed({7'd0, cfg.clip_rows}) - 18'sd1;
      empty = (bc == 11'd0) || (br == 11'd0) || (x2 < cx1) || (x > cx2) ||
              (y2 < cy1) || (y > cy2);
      lx = (x < cx1) ? cx1 : x;
      ty = (y < cy1) ? cy1 : y;
      rx = (x2 > cx2) ? cx2 : x2;
      rb = (y2 > cy2) ? cy2 : y2;

      in_clip = (col_ff >= skc_ff) && ({1'b0, col_ff} < ({1'b0, skc_ff} + {1'b0, bcols_ff})) &&
                (row_ff >= skr_ff) && ({1'b0, row_ff} < ({1'b0, skr_ff} + {1'b0, brows_ff}));

      if (req_op == blt_pkg::OP_PIXEL) begin
         ax = {1'b0, bx_ff} + {1'b0, col_ff} - {1'b0, skc_ff};
         ay = {1'b0, by_ff} + {1'b0, row_ff} - {1'b0, skr_ff};
      end else begin
         ax = {1'b0, bx_ff} + {1'b0, col_ff};
         ay = {1'b0, by_ff} + {1'b0, row_ff};
      end
      prod    = ay * cfg.row_pitch;
      asum    = {1'b0, prod} + {12'd0, ax};
      skr_row = {1'b0, skr_ff} + {1'b0, row_ff};
      iprod   = skr_row * svc_ff;
      isum    = {1'b0, iprod} + {13'd0, skc_ff} + {13'd0, col_ff};
      cnext   = {1'b0, col_ff} + 12'd1;
      rnext   = {1'b0, row_ff} + 12'd1;
   end

   always_comb begin
      busy_in  = busy_ff;
      mode_in  = mode_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      bcols_in = bcols_ff;
      brows_in = brows_ff;
      skc_in   = skc_ff;
      skr_in   = skr_ff;
      svc_in   = svc_ff;
      svr_in   = svr_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      push     = 1'b0;
      push_entry      = '0;
      push_entry.kind = blt_pkg::CMD_REPORT;
      push_entry.addr = asum[blt_pkg::ADDR_MAX_W-1:0];
      if (req_valid && req_ready) begin
         unique case (req_op)
            blt_pkg::OP_START: begin
               if (mode <= blt_pkg::MODE_BOX) begin
                  push    = 1'b1;
                  mode_in = mode;
                  col_in  = 11'd0;
                  row_in  = 11'd0;
                  svc_in  = bc;
                  svr_in  = br;
                  if (empty) begin
                     busy_in  = 1'b0;
                     bx_in    = 11'd0;
                     by_in    = 11'd0;
                     bcols_in = 11'd0;
                     brows_in = 11'd0;
                     skc_in   = 11'd0;
                     skr_in   = 11'd0;
                     push_entry.rect_empty = 1'b1;
                  end else begin
                     busy_in  = 1'b1;
                     bx_in    = lx[10:0];
                     by_in    = ty[10:0];
                     bcols_in = 11'(rx - lx + 18'sd1);
                     brows_in = 11'(rb - ty + 18'sd1);
                     skc_in   = 11'(lx - x);
                     skr_in   = 11'(ty - y);
                     push_entry.rect_x    = lx[15:0];
                     push_entry.rect_y    = ty[15:0];
                     push_entry.rect_cols = 11'(rx - lx + 18'sd1);
                     push_entry.rect_rows = 11'(rb - ty + 18'sd1);
                  end
               end
            end
            blt_pkg::OP_PIXEL: begin
               if (busy_ff && mode_ff >= blt_pkg::MODE_PUT &&
                   mode_ff <= blt_pkg::MODE_RECOLOUR) begin
                  if (in_clip && (mode_ff == blt_pkg::MODE_PUT || src != 8'd0)) begin
                     push = 1'b1;
                     push_entry.data = src;
                     if (mode_ff == blt_pkg::MODE_RECOLOUR) begin
                        push_entry.kind = blt_pkg::CMD_RECOLOUR;
                     end else begin
                        push_entry.kind = blt_pkg::CMD_WRITE;
                     end
                     if (mode_ff == blt_pkg::MODE_SHADOW) begin
                        push_entry.data = cfg.shadow_colour;
                     end
                  end
                  if (cnext >= {1'b0, svc_ff}) begin
                     col_in = 11'd0;
                     row_in = rnext[10:0];
                     if (rnext >= {1'b0, svr_ff}) begin
                        busy_in = 1'b0;
                     end
                  end else begin
                     col_in = cnext[10:0];
                  end
               end
            end
            blt_pkg::OP_TICK: begin
               if (busy_ff && (mode_ff == blt_pkg::MODE_GET || mode_ff == blt_pkg::MODE_BOX)) begin
                  push = 1'b1;
                  push_entry.idx = isum[19:0];
                  if (mode_ff == blt_pkg::MODE_BOX) begin
                     push_entry.kind = blt_pkg::CMD_RECOLOUR;
                  end else begin
                     push_entry.kind = blt_pkg::CMD_GET;
                  end
                  if (cnext >= {1'b0, bcols_ff}) begin
                     col_in = 11'd0;
                     row_in = rnext[10:0];
                     push_entry.last = (rnext >= {1'b0, brows_ff});
                  end else begin
                     col_in = cnext[10:0];
                     push_entry.last = (row_ff >= brows_ff);
                  end
                  if (push_entry.last) begin
                     busy_in = 1'b0;
                  end
               end
            end
            blt_pkg::OP_TABLE: begin
               push = 1'b1;
               push_entry.kind = blt_pkg::CMD_TLOAD;
               push_entry.idx  = {12'd0, tidx};
               push_entry.data = tval;
            end
            default: push = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         mode_ff  <= 3'd0;
         bx_ff    <= 11'd0;
         by_ff    <= 11'd0;
         bcols_ff <= 11'd0;
         brows_ff <= 11'd0;
         skc_ff   <= 11'd0;
         skr_ff   <= 11'd0;
         svc_ff   <= 11'd0;
         svr_ff   <= 11'd0;
         col_ff   <= 11'd0;
         row_ff   <= 11'd0;
      end else begin
         busy_ff  <= busy_in;
         mode_ff  <= mode_in;
         bx_ff    <= bx_in;
         by_ff    <= by_in;
         bcols_ff <= bcols_in;
         brows_ff <= brows_in;
         skc_ff   <= skc_in;
         skr_ff   <= skr_in;
         svc_ff   <= svc_in;
         svr_ff   <= svr_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

endmodule

FILE: src/blt_queue.sv
// ----------------------------------------------------------------------------
// Blitter command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module blt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  blt_pkg::blt_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output blt_pkg::blt_entry_type head
);

   blt_pkg::blt_entry_type slot_ff [blt_pkg::QUEUE_DEPTH];
   logic [blt_pkg::QUEUE_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [blt_pkg::QUEUE_PTR_W:0]   cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full       = (cnt_ff == (blt_pkg::QUEUE_PTR_W+1)'(blt_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{blt_pkg::QUEUE_PTR_W{1'b0}}, do_push}
                      - {{blt_pkg::QUEUE_PTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: src/blt_back.sv
// ----------------------------------------------------------------------------
// Blitter back end
// Carries out queued commands on the frame store and the recolour table.
// ----------------------------------------------------------------------------
module blt_back #(
   parameter int FRAME_BYTES = blt_pkg::FRAME_BYTES_DEF,
   parameter int ADDR_W      = $clog2(FRAME_BYTES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  blt_pkg::blt_entry_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_kind,
   output logic [82:0]            rsp_data,
   output logic                   rsp_last
);

   logic [7:0] frame_mem [FRAME_BYTES];
   logic [7:0] table_mem [256];

   blt_pkg::blt_back_state_type state_ff, state_in;
   blt_pkg::blt_entry_type      cur_ff, cur_in;
   logic [7:0] fr_rdata_ff, tb_rdata_ff;
   logic       fr_re, fr_we, tb_re, tb_we;
   logic [ADDR_W-1:0] fr_waddr;
   logic [7:0] fr_wdata;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in, out_last_ff, out_last_in;
   logic [82:0] out_data_ff, out_data_in;
   logic        out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_data  = out_data_ff;
   assign rsp_last  = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      pop          = 1'b0;
      fr_re        = 1'b0;
      fr_we        = 1'b0;
      tb_re        = 1'b0;
      tb_we        = 1'b0;
      fr_waddr     = head.addr[ADDR_W-1:0];
      fr_wdata     = head.data;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      out_data_in  = out_data_ff;
      unique case (state_ff)
         blt_pkg::BK_IDLE: begin
            if (head_valid) begin
               unique case (head.kind)
                  blt_pkg::CMD_REPORT: begin
                     if (out_free) begin
                        pop          = 1'b1;
                        out_valid_in = 1'b1;
                        out_kind_in  = 1'b0;
                        out_last_in  = 1'b0;
                        out_data_in  = {20'd0, 8'd0, head.rect_empty, head.rect_rows,
                                        head.rect_cols, head.rect_y, head.rect_x};
                     end
                  end
                  blt_pkg::CMD_WRITE: begin
                     pop   = 1'b1;
                     fr_we = 1'b1;
                  end
                  blt_pkg::CMD_TLOAD: begin
                     pop   = 1'b1;
                     tb_we = 1'b1;
                  end
                  blt_pkg::CMD_RECOLOUR: begin
                     pop      = 1'b1;
                     fr_re    = 1'b1;
                     cur_in   = head;
                     state_in = blt_pkg::BK_RC_TBL;
                  end
                  blt_pkg::CMD_GET: begin
                     pop      = 1'b1;
                     fr_re    = 1'b1;
                     cur_in   = head;
                     state_in = blt_pkg::BK_GET_OUT;
                  end
                  default: pop = 1'b0;
               endcase
            end
         end
         blt_pkg::BK_RC_TBL: begin
            tb_re    = 1'b1;
            state_in = blt_pkg::BK_RC_WR;
         end
         blt_pkg::BK_RC_WR: begin
            fr_we    = 1'b1;
            fr_waddr = cur_ff.addr[ADDR_W-1:0];
            fr_wdata = tb_rdata_ff;
            state_in = blt_pkg::BK_IDLE;
         end
         blt_pkg::BK_GET_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = 1'b1;
               out_last_in  = cur_ff.last;
               out_data_in  = {cur_ff.idx, fr_rdata_ff, 55'd0};
               state_in     = blt_pkg::BK_IDLE;
            end
         end
         default: state_in = blt_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fr_we) begin
         frame_mem[fr_waddr] <= fr_wdata;
      end
      if (fr_re) begin
         fr_rdata_ff <= frame_mem[head.addr[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (tb_we) begin
         table_mem[head.idx[7:0]] <= head.data;
      end
      if (tb_re) begin
         tb_rdata_ff <= table_mem[fr_rdata_ff];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blt_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Clipped block blitter testbench
// Drives start commands, source pixels, step ticks and table loads through
// the request stream, and checks every dirty rectangle report and every get
// pixel against a cycle-free predictor or a directed table, under random
// sender gaps, receiver stalls and several clip, offset and pitch settings.
// ----------------------------------------------------------------------------
module testbench;
   import blt_pkg::*;

   typedef struct {
      logic [1:0]         op;
      logic [2:0]         mode;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [10:0]        cols;
      logic [10:0]        rows;
      logic [7:0]         pixel;
      logic [7:0]         tbl_index;
      logic [7:0]         tbl_value;
   } blit_req_t;

   typedef struct packed {
      logic        kind;
      logic [15:0] rect_x;
      logic [15:0] rect_y;
      logic [10:0] rect_cols;
      logic [10:0] rect_rows;
      logic        rect_empty;
      logic [7:0]  read_pixel;
      logic [19:0] buffer_index;
      logic        last;
   } blit_rsp_t;

   typedef struct {
      blit_req_t q;
      bit        typed;
      blit_rsp_t r;
   } dir_row_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [87:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   clipped_block_blitter dut (.*);

   initial forever #6 clock = ~clock;

   initial begin
      #(12 * 3000000);
      $display("clipped_block_blitter regression: fail");
      $finish;
   end

   // Predictor state.
   logic [7:0] frame_mirror [65536];
   bit         frame_known [65536];
   logic [7:0] table_mirror [256];
   int clip_l = 0, clip_t = 0, clip_c = 320, clip_r = 200;
   int org_x = 0, org_y = 0, pitch = 320, shadow = 0;
   int cur_mode = 0, bx = 0, by = 0, bcols = 0, brows = 0;
   int scol = 0, srow = 0, scols = 0, srows = 0, skc = 0, skr = 0;
   bit busy = 0;

   blit_rsp_t pending_rsps [$];
   int mismatches = 0, results_seen = 0, items_sent = 0;

   function automatic int frame_addr(int x, int y);
      return (y * pitch + x) & 16'hFFFF;
   endfunction

   // True when every frame entry of the clipped block has been written.
   function automatic bit block_known(input blit_req_t q);
      int bc, br, x, y, x2, y2, cx2, cy2, lx, ty, rx, byy;
      bc = (q.cols > 1024) ? 1024 : q.cols;
      br = (q.rows > 1024) ? 1024 : q.rows;
      x = int'(q.pos_x) + org_x;
      y = int'(q.pos_y) + org_y;
      x2 = x + bc - 1;
      y2 = y + br - 1;
      cx2 = clip_l + clip_c - 1;
      cy2 = clip_t + clip_r - 1;
      if (bc == 0 || br == 0 || x2 < clip_l || x > cx2 || y2 < clip_t || y > cy2)
         return 1'b1;
      lx = (x < clip_l) ? clip_l : x;
      ty = (y < clip_t) ? clip_t : y;
      rx = (x2 > cx2) ? cx2 : x2;
      byy = (y2 > cy2) ? cy2 : y2;
      for (int j = ty; j <= byy; j++)
         for (int i = lx; i <= rx; i++)
            if (!frame_known[frame_addr(i, j)]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic predict_blit(input blit_req_t q, output bit has, output blit_rsp_t r);
      int bc, br, x, y, x2, y2, cx2, cy2, lx, ty, rx, byy, c, rw, a;
      bit in_clip;
      logic [7:0] px;
      has = 0;
      r = '{default: '0};
      if (q.op == OP_START) begin
         if (q.mode > MODE_BOX) return;
         bc = (q.cols > 1024) ? 1024 : q.cols;
         br = (q.rows > 1024) ? 1024 : q.rows;
         x = int'(q.pos_x) + org_x;
         y = int'(q.pos_y) + org_y;
         x2 = x + bc - 1;
         y2 = y + br - 1;
         cx2 = clip_l + clip_c - 1;
         cy2 = clip_t + clip_r - 1;
         cur_mode = q.mode;
         scol = 0; srow = 0; scols = bc; srows = br;
         has = 1;
         if (bc == 0 || br == 0 || x2 < clip_l || x > cx2 || y2 < clip_t || y > cy2) begin
            busy = 0;
            bx = 0; by = 0; bcols = 0; brows = 0; skc = 0; skr = 0;
            r.rect_empty = 1;
            return;
         end
         lx = (x < clip_l) ? clip_l : x;
         ty = (y < clip_t) ? clip_t : y;
         rx = (x2 > cx2) ? cx2 : x2;
         byy = (y2 > cy2) ? cy2 : y2;
         bx = lx; by = ty; bcols = rx - lx + 1; brows = byy - ty + 1;
         skc = lx - x; skr = ty - y;
         busy = 1;
         r.rect_x = bx; r.rect_y = by; r.rect_cols = bcols; r.rect_rows = brows;
         return;
      end
      if (q.op == OP_TABLE) begin
         table_mirror[q.tbl_index] = q.tbl_value;
         return;
      end
      if (!busy) return;
      c = scol; rw = srow;
      if (q.op == OP_PIXEL) begin
         if (cur_mode < MODE_PUT || cur_mode > MODE_RECOLOUR) return;
         in_clip = c >= skc && c < skc + bcols && rw >= skr && rw < skr + brows;
         a = frame_addr(bx + c - skc, by + rw - skr);
         if (in_clip && q.pixel != 0) begin
            case (cur_mode)
               MODE_PUT, MODE_MASKED: frame_mirror[a] = q.pixel;
               MODE_SHADOW: frame_mirror[a] = shadow[7:0];
               default: frame_mirror[a] = table_mirror[frame_mirror[a]];
            endcase
            frame_known[a] = 1;
         end else if (in_clip && cur_mode == MODE_PUT) begin
            frame_mirror[a] = 8'd0;
            frame_known[a] = 1;
         end
         c++;
         if (c >= scols) begin
            c = 0;
            rw++;
            if (rw >= srows) busy = 0;
         end
         scol = c; srow = rw;
         return;
      end
      if (cur_mode != MODE_GET && cur_mode != MODE_BOX) return;
      a = frame_addr(bx + c, by + rw);
      r.buffer_index = (skr + rw) * scols + skc + c;
      px = frame_mirror[a];
      c++;
      if (c >= bcols) begin
         c = 0;
         rw++;
      end
      if (rw >= brows) busy = 0;
      r.last = rw >= brows;
      scol = c; srow = rw;
      if (cur_mode == MODE_BOX) begin
         frame_mirror[a] = table_mirror[px];
         return;
      end
      r.kind = 1;
      r.read_pixel = px;
      has = 1;
   endtask

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;

   task automatic send_req(input blit_req_t q, input bit typed = 0,
                           input blit_rsp_t typed_rsp = '{default: '0});
      int gap;
      bit hs, has;
      blit_rsp_t r;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= q.op;
      req_tdata <= {7'd0, q.tbl_value, q.tbl_index, q.pixel, q.rows, q.cols,
                    q.pos_y, q.pos_x, q.mode};
      do begin
         @(negedge clock);
         hs = req_tready;
         @(posedge clock);
      end while (!hs);
      predict_blit(q, has, r);
      if (typed) pending_rsps.push_back(typed_rsp);
      else if (has) pending_rsps.push_back(r);
      items_sent++;
   endtask

   task automatic idle_req();
      req_tvalid <= 0;
      burst_left = 0;
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input int value);
      bit hs;
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      do begin
         @(negedge clock);
         hs = csr_pready;
         @(posedge clock);
      end while (!hs);
      csr_psel <= 0;
      csr_penable <= 0;
      case (index)
         REG_CLIP_LEFT: clip_l = value & 32'h3FF;
         REG_CLIP_TOP:  clip_t = value & 32'h3FF;
         REG_CLIP_COLS: clip_c = value & 32'h7FF;
         REG_CLIP_ROWS: clip_r = value & 32'h7FF;
         REG_ORIGIN_X:  org_x = int'(signed'(value[10:0]));
         REG_ORIGIN_Y:  org_y = int'(signed'(value[10:0]));
         REG_PITCH:     pitch = value & 32'h7FF;
         default:       shadow = value & 32'hFF;
      endcase
   endtask

   task automatic write_all_csrs(input int l, t, c, r, ox, oy, p, s);
      write_csr(REG_CLIP_LEFT, l);
      write_csr(REG_CLIP_TOP, t);
      write_csr(REG_CLIP_COLS, c);
      write_csr(REG_CLIP_ROWS, r);
      write_csr(REG_ORIGIN_X, ox);
      write_csr(REG_ORIGIN_Y, oy);
      write_csr(REG_PITCH, p);
      write_csr(REG_SHADOW, s);
   endtask

   task automatic drain_rsps();
      idle_req();
      while (pending_rsps.size() > 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   function automatic blit_req_t mk_req(input logic [1:0] op, input logic [2:0] mode = 0,
                                        input int px = 0, input int py = 0,
                                        input int bc = 0, input int br = 0,
                                        input int pix = 0, input int ti = 0,
                                        input int tv = 0);
      blit_req_t q;
      q.op = op; q.mode = mode; q.pos_x = px; q.pos_y = py;
      q.cols = bc; q.rows = br; q.pixel = pix; q.tbl_index = ti; q.tbl_value = tv;
      return q;
   endfunction

   function automatic dir_row_t mk_row(input blit_req_t q, input bit typed = 0,
                                       input int ex = 0, input int ey = 0,
                                       input int ec = 0, input int er = 0,
                                       input bit ee = 0);
      dir_row_t d;
      d.q = q;
      d.typed = typed;
      d.r = '{default: '0};
      d.r.rect_x = ex; d.r.rect_y = ey; d.r.rect_cols = ec; d.r.rect_rows = er;
      d.r.rect_empty = ee;
      return d;
   endfunction

   // Receiver stall pattern.
   logic [15:0] rx_cycle = 0;
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case (rx_cycle[11:10])
         2'd0: rsp_tready <= 1;
         2'd1: rsp_tready <= (rx_cycle % 7) != 0;
         2'd2: rsp_tready <= $urandom_range(0, 3) != 0;
         default: rsp_tready <= rx_cycle[4:2] != 3'd0;
      endcase
   end

   always @(negedge clock) begin
      blit_rsp_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.rect_x = rsp_tdata[15:0];
         got.rect_y = rsp_tdata[31:16];
         got.rect_cols = rsp_tdata[42:32];
         got.rect_rows = rsp_tdata[53:43];
         got.rect_empty = rsp_tdata[54];
         got.read_pixel = rsp_tdata[62:55];
         got.buffer_index = rsp_tdata[82:63];
         got.last = rsp_tlast;
         results_seen++;
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_rsps.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   task automatic run_sequence();
      blit_req_t q, fill;
      int mode, bc, br, n, kind;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         q.op = $urandom; q.mode = $urandom; q.pos_x = $urandom; q.pos_y = $urandom;
         q.cols = $urandom; q.rows = $urandom; q.pixel = $urandom;
         q.tbl_index = $urandom; q.tbl_value = $urandom;
         if (q.op == OP_START) begin
            q.cols = $urandom_range(0, 40);
            if (q.mode == MODE_GET || q.mode == MODE_RECOLOUR || q.mode == MODE_BOX)
               q.mode = MODE_PUT;
         end
         send_req(q);
         return;
      end
      if (kind == 1) begin
         send_req(mk_req(OP_TABLE, 0, 0, 0, 0, 0, 0, $urandom_range(0, 255),
                         $urandom_range(0, 255)));
         return;
      end
      mode = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
      bc = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      br = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      q = mk_req(OP_START, mode);
      q.cols = bc; q.rows = br;
      if ($urandom_range(0, 19) == 0) begin
         q.pos_x = $urandom; q.pos_y = $urandom;
      end else begin
         q.pos_x = clip_l - org_x + $urandom_range(0, clip_c + 16) - 10;
         q.pos_y = clip_t - org_y + $urandom_range(0, clip_r + 16) - 10;
      end
      // Modes that read the frame first get the whole block painted if any of it is still unwritten.
      if ((q.mode == MODE_GET || q.mode == MODE_RECOLOUR || q.mode == MODE_BOX) &&
          !block_known(q)) begin
         fill = q;
         fill.mode = MODE_PUT;
         send_req(fill);
         n = scols * srows;
         for (int i = 0; i < n; i++)
            send_req(mk_req(OP_PIXEL, 0, 0, 0, 0, 0, $urandom_range(0, 255)));
      end
      send_req(q);
      if (!busy) return;
      if (cur_mode >= MODE_PUT && cur_mode <= MODE_RECOLOUR) n = scols * srows;
      else n = bcols * brows;
      if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 29) == 0)
            send_req(mk_req(OP_TABLE, 0, 0, 0, 0, 0, 0, $urandom_range(0, 255),
                            $urandom_range(0, 255)));
         if (cur_mode >= MODE_PUT && cur_mode <= MODE_RECOLOUR)
            send_req(mk_req(($urandom_range(0, 19) == 0) ? OP_TICK : OP_PIXEL, 0, 0, 0,
                            0, 0, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 255)));
         else
            send_req(mk_req(($urandom_range(0, 19) == 0) ? OP_PIXEL : OP_TICK, 0, 0, 0,
                            0, 0, $urandom_range(0, 255)));
      end
   endtask

   initial begin
      dir_row_t rows [];
      int target;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      rows = '{
         mk_row(mk_req(OP_START, MODE_PUT, 0, 0, 10, 10), 1, 0, 0, 10, 10, 0),
         mk_row(mk_req(OP_START, MODE_GET, 0, 0, 0, 5), 1, 0, 0, 0, 0, 1),
         mk_row(mk_req(OP_START, MODE_MASKED, 400, 0, 4, 4), 1, 0, 0, 0, 0, 1),
         mk_row(mk_req(OP_START, MODE_SHADOW, -5, -5, 10, 10), 1, 0, 0, 5, 5, 0),
         mk_row(mk_req(OP_START, MODE_RECOLOUR, 0, 0, 2047, 2047), 1, 0, 0, 320, 200, 0),
         mk_row(mk_req(OP_START, MODE_BOX, 32767, 32767, 4, 4), 1, 0, 0, 0, 0, 1),
         mk_row(mk_req(OP_START, MODE_GET, -32768, -32768, 1024, 1024), 1, 0, 0, 0, 0, 1),
         mk_row(mk_req(OP_START, 3'd6, 0, 0, 4, 4)),
         mk_row(mk_req(OP_START, 3'd7, 0, 0, 4, 4)),
         mk_row(mk_req(OP_START, MODE_PUT, 316, 196, 8, 8), 1, 316, 196, 4, 4, 0),
         mk_row(mk_req(OP_START, MODE_PUT, 0, 0, 0, 0), 1, 0, 0, 0, 0, 1),
         mk_row(mk_req(OP_PIXEL, 0, 0, 0, 0, 0, 255)),
         mk_row(mk_req(OP_TICK)),
         mk_row(mk_req(OP_TABLE, 0, 0, 0, 0, 0, 0, 0, 255)),
         mk_row(mk_req(OP_TABLE, 0, 0, 0, 0, 0, 0, 255, 0)),
         mk_row(mk_req(OP_START, MODE_GET, 319, 199, 1, 1), 1, 319, 199, 1, 1, 0),
         mk_row(mk_req(OP_PIXEL, 0, 0, 0, 0, 0, 7)),
         mk_row(mk_req(OP_START, MODE_PUT, 0, 0, 1, 1), 1, 0, 0, 1, 1, 0),
         mk_row(mk_req(OP_TICK)),
         mk_row(mk_req(OP_START, MODE_PUT, 0, 0, 0, 0), 1, 0, 0, 0, 0, 1)
      };
      foreach (rows[i]) send_req(rows[i].q, rows[i].typed, rows[i].r);
      drain_rsps();

      // Fill the recolour table before anything reads it.
      for (int i = 0; i < 256; i++)
         send_req(mk_req(OP_TABLE, 0, 0, 0, 0, 0, 0, i, $urandom_range(0, 255)));
      drain_rsps();

      target = items_sent;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_all_csrs(1023, 1023, 1024, 1024, -1024, -1024, 1024, 255);
            1: write_all_csrs(0, 0, 1, 1, 1023, 1023, 1, 0);
            2: write_all_csrs(0, 0, 320, 200, 0, 0, 320, 0);
            default: write_all_csrs($urandom_range(0, 1023), $urandom_range(0, 1023),
                                    $urandom_range(1, 40), $urandom_range(1, 40),
                                    $urandom_range(0, 2047), $urandom_range(0, 2047),
                                    $urandom_range(1, 1024), $urandom_range(0, 255));
         endcase
         target += 170;
         while (items_sent < target) run_sequence();
         drain_rsps();
      end

      $display("sent %0d requests over 8 register settings, checked %0d results",
               items_sent, results_seen);
      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("clipped_block_blitter regression: pass");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_rsps.size());
         $display("clipped_block_blitter regression: fail");
      end
      $finish;
   end
endmodule
